// File: hdl/csl_pkg.sv
`timescale 1ns / 1ps

package csl_pkg;

   localparam int NUM_COLOR_REGS = 6;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_INDEX_W    = 3;
   localparam int COUNT_W        = 3;
   localparam int COLOR_W        = 32;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHANS      = 4;

   localparam int DEF_POS_FRAC_BITS = 16;

   // stops actually usable; a larger count saturates to this
   localparam logic [COUNT_W-1:0] MAX_COLORS = 3'd6;

   localparam logic [COLOR_W-1:0] WHITE = 32'hFFFF_FFFF;

   // register indexes (byte address is 4 * index)
   localparam logic [CSR_INDEX_W-1:0] REG_COLOR_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRADIENT_MODE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLOR_0       = 3'd2;

   typedef struct packed {
      logic [COUNT_W-1:0]                            color_count;
      logic                                          gradient_mode;
      logic [NUM_COLOR_REGS-1:0][COLOR_W-1:0]        colors;
   } csr_cfg_type;

   // stop count after saturation
   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
      eff_count = (cnt > MAX_COLORS) ? MAX_COLORS : cnt;
   endfunction

endpackage

// File: hdl/csl_csr.sv
`timescale 1ns / 1ps

module csl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [csl_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output csl_pkg::csr_cfg_type                 cfg
);

   csl_pkg::csr_cfg_type               cfg_ff;
   csl_pkg::csr_cfg_type               cfg_in;
   logic [csl_pkg::CSR_INDEX_W-1:0]    index;
   logic                               wr_en;

   assign index  = paddr[csl_pkg::CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            csl_pkg::REG_COLOR_COUNT: begin
               cfg_in.color_count = pwdata[csl_pkg::COUNT_W-1:0];
            end
            csl_pkg::REG_GRADIENT_MODE: begin
               cfg_in.gradient_mode = pwdata[0];
            end
            default: begin
               cfg_in.colors[index - csl_pkg::REG_COLOR_0] = pwdata;
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         csl_pkg::REG_COLOR_COUNT: begin
            prdata = {{(32 - csl_pkg::COUNT_W){1'b0}}, cfg_ff.color_count};
         end
         csl_pkg::REG_GRADIENT_MODE: begin
            prdata = {31'd0, cfg_ff.gradient_mode};
         end
         default: begin
            prdata = cfg_ff.colors[index - csl_pkg::REG_COLOR_0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_count   <= '0;
         cfg_ff.gradient_mode <= 1'b1;
         for (int i = 0; i < csl_pkg::NUM_COLOR_REGS; i++) begin
            cfg_ff.colors[i] <= csl_pkg::WHITE;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/csl_locate.sv
`timescale 1ns / 1ps

// Stages 1 and 2: scale the position, then find the segment (or bin),
// its two end colours and the fraction within it.
module csl_locate #(
   parameter int POS_FRAC_BITS = csl_pkg::DEF_POS_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  csl_pkg::csr_cfg_type                 cfg,
   input  logic                                 in_valid,
   input  logic [POS_FRAC_BITS:0]               in_position,
   output logic                                 seg_valid,
   output logic [csl_pkg::COLOR_W-1:0]          seg_start,
   output logic [csl_pkg::COLOR_W-1:0]          seg_end,
   output logic [POS_FRAC_BITS:0]               seg_frac
);

   localparam int POS_W = POS_FRAC_BITS + 1;
   localparam int T_W   = POS_FRAC_BITS + 4;
   localparam logic [POS_W-1:0] POS_ONE = {1'b1, {POS_FRAC_BITS{1'b0}}};

   logic [csl_pkg::COUNT_W-1:0]   n_eff;
   logic [csl_pkg::COUNT_W-1:0]   n_less1;
   logic [POS_W-1:0]              pos_sat;
   logic [csl_pkg::COUNT_W-1:0]   mult;

   logic                          v1_ff;
   logic [T_W-1:0]                t_ff;
   logic [T_W-1:0]                t_in;

   logic [3:0]                    k_raw;
   logic [csl_pkg::COUNT_W-1:0]   k;
   logic [POS_W-1:0]              frac_g;
   logic [T_W:0]                  c_sum;
   logic [4:0]                    c;
   logic [4:0]                    idx_raw;
   logic [csl_pkg::COUNT_W-1:0]   idx;

   logic                          v2_ff;
   logic [csl_pkg::COLOR_W-1:0]   start_ff;
   logic [csl_pkg::COLOR_W-1:0]   start_in;
   logic [csl_pkg::COLOR_W-1:0]   end_ff;
   logic [csl_pkg::COLOR_W-1:0]   end_in;
   logic [POS_W-1:0]              frac_ff;
   logic [POS_W-1:0]              frac_in;

   assign n_eff   = csl_pkg::eff_count(cfg.color_count);
   assign n_less1 = n_eff - 3'd1;

   // stage 1: clamp to 1.0 and scale by the segment or bin count
   always_comb begin
      pos_sat = (in_position > POS_ONE) ? POS_ONE : in_position;
      mult    = cfg.gradient_mode ? n_less1 : n_eff;
      t_in    = T_W'(pos_sat) * T_W'(mult);
   end

   // stage 2: segment index and fraction
   always_comb begin
      k_raw = t_ff[T_W-1:POS_FRAC_BITS];
      if (k_raw >= {1'b0, n_less1}) begin
         k = n_eff - 3'd2;
      end else begin
         k = k_raw[csl_pkg::COUNT_W-1:0];
      end
      frac_g = POS_W'(t_ff - (T_W'(k) << POS_FRAC_BITS));

      // step mode: ceil(t) - 1, floored at zero, capped at the last stop
      c_sum   = (T_W+1)'(t_ff) + (T_W+1)'(POS_ONE - 1'b1);
      c       = c_sum[T_W:POS_FRAC_BITS];
      idx_raw = (c == 5'd0) ? 5'd0 : c - 5'd1;
      if (idx_raw > {2'b00, n_less1}) begin
         idx = n_less1;
      end else begin
         idx = idx_raw[csl_pkg::COUNT_W-1:0];
      end
   end

   // flat results travel as start = end with zero fraction
   always_comb begin
      priority if (n_eff == 3'd0) begin
         start_in = csl_pkg::WHITE;
         end_in   = csl_pkg::WHITE;
         frac_in  = '0;
      end else if (n_eff == 3'd1) begin
         start_in = cfg.colors[0];
         end_in   = cfg.colors[0];
         frac_in  = '0;
      end else if (cfg.gradient_mode) begin
         start_in = cfg.colors[k];
         end_in   = cfg.colors[k + 3'd1];
         frac_in  = frac_g;
      end else begin
         start_in = cfg.colors[idx];
         end_in   = cfg.colors[idx];
         frac_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      frac_ff  <= frac_in;
   end

   assign seg_valid = v2_ff;
   assign seg_start = start_ff;
   assign seg_end   = end_ff;
   assign seg_frac  = frac_ff;

endmodule

// File: hdl/csl_blend.sv
`timescale 1ns / 1ps

// Stages 3 and 4: per-channel multiply, then round the result toward zero
// and add or subtract.
module csl_blend #(
   parameter int POS_FRAC_BITS = csl_pkg::DEF_POS_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 seg_valid,
   input  logic [csl_pkg::COLOR_W-1:0]          seg_start,
   input  logic [csl_pkg::COLOR_W-1:0]          seg_end,
   input  logic [POS_FRAC_BITS:0]               seg_frac,
   output logic                                 out_valid,
   output logic [csl_pkg::COLOR_W-1:0]          out_color
);

   localparam int POS_W  = POS_FRAC_BITS + 1;
   localparam int PROD_W = csl_pkg::CHAN_W + POS_W;
   localparam logic [PROD_W:0] ROUND_UP = (PROD_W+1)'((1 << POS_FRAC_BITS) - 1);

   logic                          v3_ff;
   logic                          v4_ff;
   logic [PROD_W-1:0]             prod_ff  [csl_pkg::NUM_CHANS];
   logic [PROD_W-1:0]             prod_in  [csl_pkg::NUM_CHANS];
   logic [csl_pkg::CHAN_W-1:0]    s_ff     [csl_pkg::NUM_CHANS];
   logic                          up_ff    [csl_pkg::NUM_CHANS];
   logic                          up_in    [csl_pkg::NUM_CHANS];
   logic [csl_pkg::COLOR_W-1:0]   color_ff;
   logic [csl_pkg::COLOR_W-1:0]   color_in;

   always_comb begin
      for (int i = 0; i < csl_pkg::NUM_CHANS; i++) begin
         logic [csl_pkg::CHAN_W-1:0] s;
         logic [csl_pkg::CHAN_W-1:0] e;
         logic [csl_pkg::CHAN_W-1:0] diff;
         s          = seg_start[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W];
         e          = seg_end[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W];
         up_in[i]   = (e >= s);
         diff       = up_in[i] ? e - s : s - e;
         prod_in[i] = PROD_W'(diff) * PROD_W'(seg_frac);
      end
   end

   // falling ramps round the step up so the result is truncated toward zero
   always_comb begin
      for (int i = 0; i < csl_pkg::NUM_CHANS; i++) begin
         logic [PROD_W:0]            sum;
         logic [csl_pkg::CHAN_W-1:0] d;
         sum = up_ff[i] ? (PROD_W+1)'(prod_ff[i])
                        : (PROD_W+1)'(prod_ff[i]) + ROUND_UP;
         d   = sum[POS_FRAC_BITS +: csl_pkg::CHAN_W];
         color_in[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W] = up_ff[i] ? s_ff[i] + d
                                                                    : s_ff[i] - d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= seg_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < csl_pkg::NUM_CHANS; i++) begin
         prod_ff[i] <= prod_in[i];
         up_ff[i]   <= up_in[i];
         s_ff[i]    <= seg_start[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W];
      end
      color_ff <= color_in;
   end

   assign out_valid = v4_ff;
   assign out_color = color_ff;

endmodule

// File: hdl/color_scale_lookup_core.sv
`timescale 1ns / 1ps

// Colour scale lookup: maps a position in [0,1] (POS_FRAC_BITS fraction bits,
// values above 1.0 clamp to 1.0) to an RGBA colour from up to six evenly
// spaced stops, interpolated or stepped. busy is always low: a beat is taken
// on every cycle that start is high, and its colour appears on the rsp_ ports
// with rsp_strobe after the four register stages, one result per cycle. The
// stages are scale, segment select, channel multiply, round and add.
// The result cannot be held off, so the receiver must take it in that cycle.
// Registers sit on the APB port at byte addresses 0x00 count, 0x04 mode,
// 0x08..0x1C colours; change them only while no lookup is in flight.
module color_scale_lookup_core #(
   parameter int POS_FRAC_BITS = csl_pkg::DEF_POS_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [POS_FRAC_BITS:0]               req_position,
   output logic                                 rsp_strobe,
   output logic [csl_pkg::CHAN_W-1:0]           rsp_red,
   output logic [csl_pkg::CHAN_W-1:0]           rsp_green,
   output logic [csl_pkg::CHAN_W-1:0]           rsp_blue,
   output logic [csl_pkg::CHAN_W-1:0]           rsp_alpha,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [csl_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   csl_pkg::csr_cfg_type          cfg;
   logic                          seg_valid;
   logic [csl_pkg::COLOR_W-1:0]   seg_start;
   logic [csl_pkg::COLOR_W-1:0]   seg_end;
   logic [POS_FRAC_BITS:0]        seg_frac;
   logic                          out_valid;
   logic [csl_pkg::COLOR_W-1:0]   out_color;

   assign busy = 1'b0;

   csl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   csl_locate #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_locate (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (start & ~busy),
      .in_position (req_position),
      .seg_valid   (seg_valid),
      .seg_start   (seg_start),
      .seg_end     (seg_end),
      .seg_frac    (seg_frac)
   );

   csl_blend #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (seg_valid),
      .seg_start (seg_start),
      .seg_end   (seg_end),
      .seg_frac  (seg_frac),
      .out_valid (out_valid),
      .out_color (out_color)
   );

   assign rsp_strobe = out_valid;
   assign rsp_red    = out_color[7:0];
   assign rsp_green  = out_color[15:8];
   assign rsp_blue   = out_color[23:16];
   assign rsp_alpha  = out_color[31:24];

endmodule

// File: tb/color_scale_lookup_core_test.sv
`timescale 1ns / 1ps

module color_scale_lookup_core_test;

   localparam int FRAC_BITS   = csl_pkg::DEF_POS_FRAC_BITS;
   localparam int POS_W       = FRAC_BITS + 1;
   localparam int POS_ONE     = 1 << FRAC_BITS;
   localparam int DRAIN_WAIT  = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 55;

   localparam logic [csl_pkg::CSR_INDEX_W-1:0] REG_LAST =
      csl_pkg::CSR_INDEX_W'(csl_pkg::REG_COLOR_0 + csl_pkg::NUM_COLOR_REGS - 1);

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [POS_W-1:0]               req_position;
   logic                           rsp_strobe;
   logic [csl_pkg::CHAN_W-1:0]     rsp_red;
   logic [csl_pkg::CHAN_W-1:0]     rsp_green;
   logic [csl_pkg::CHAN_W-1:0]     rsp_blue;
   logic [csl_pkg::CHAN_W-1:0]     rsp_alpha;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [csl_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                    pwdata;
   logic [31:0]                    prdata;
   logic                           pready;

   color_scale_lookup_core #(.POS_FRAC_BITS(FRAC_BITS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_position(req_position),
      .rsp_strobe(rsp_strobe), .rsp_red(rsp_red), .rsp_green(rsp_green),
      .rsp_blue(rsp_blue), .rsp_alpha(rsp_alpha),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // colour lookup mirror plus the queue of colours still owed by the core
   class colour_scoreboard;
      // [0] red .. [3] alpha
      typedef bit [csl_pkg::NUM_CHANS-1:0][csl_pkg::CHAN_W-1:0] rgba_type;

      bit [csl_pkg::COUNT_W-1:0] stop_count;
      bit                        blend_on;
      bit [csl_pkg::COLOR_W-1:0] stop_colour [csl_pkg::NUM_COLOR_REGS];
      rgba_type                  owed_q [$];
      int                        faults;

      function new();
         stop_count = '0;
         blend_on   = 1'b1;
         foreach (stop_colour[i]) stop_colour[i] = csl_pkg::WHITE;
         faults = 0;
      endfunction

      function void write_reg(int idx, bit [31:0] value);
         if (idx == csl_pkg::REG_COLOR_COUNT)
            stop_count = value[csl_pkg::COUNT_W-1:0];
         else if (idx == csl_pkg::REG_GRADIENT_MODE)
            blend_on = value[0];
         else if (idx >= csl_pkg::REG_COLOR_0 &&
                  idx < csl_pkg::REG_COLOR_0 + csl_pkg::NUM_COLOR_REGS)
            stop_colour[idx - csl_pkg::REG_COLOR_0] = value;
      endfunction

      function int used_stops();
         return (stop_count > csl_pkg::MAX_COLORS) ? int'(csl_pkg::MAX_COLORS)
                                                   : int'(stop_count);
      endfunction

      // falling channels round the step up so the result truncates toward zero
      function bit [csl_pkg::CHAN_W-1:0] blend(bit [csl_pkg::CHAN_W-1:0] s,
                                               bit [csl_pkg::CHAN_W-1:0] e,
                                               bit [63:0] frac);
         bit [63:0] span;
         bit [63:0] delta;
         if (e >= s) begin
            span  = 64'(e) - 64'(s);
            delta = (span * frac) >> FRAC_BITS;
            return s + delta[csl_pkg::CHAN_W-1:0];
         end
         span  = 64'(s) - 64'(e);
         delta = (span * frac + 64'(POS_ONE - 1)) >> FRAC_BITS;
         return s - delta[csl_pkg::CHAN_W-1:0];
      endfunction

      function rgba_type lookup(bit [POS_W-1:0] position);
         bit [63:0]                 pos;
         bit [63:0]                 t;
         bit [63:0]                 seg;
         bit [63:0]                 frac;
         bit [63:0]                 idx;
         bit [csl_pkg::COLOR_W-1:0] lo;
         bit [csl_pkg::COLOR_W-1:0] hi;
         rgba_type                  colour;
         int                        n;
         n   = used_stops();
         pos = (position > POS_ONE) ? 64'(POS_ONE) : 64'(position);
         if (n == 0) begin
            colour = csl_pkg::WHITE;
         end else if (n == 1) begin
            colour = stop_colour[0];
         end else if (blend_on) begin
            t   = pos * 64'(n - 1);
            seg = t >> FRAC_BITS;
            if (seg >= 64'(n - 1)) seg = 64'(n - 2);
            frac = t - (seg << FRAC_BITS);
            lo   = stop_colour[seg];
            hi   = stop_colour[seg + 1];
            for (int i = 0; i < csl_pkg::NUM_CHANS; i++)
               colour[i] = blend(lo[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W],
                                 hi[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W], frac);
         end else begin
            t   = (pos * 64'(n) + 64'(POS_ONE - 1)) >> FRAC_BITS;
            idx = (t == 0) ? 64'd0 : t - 1;
            if (idx > 64'(n - 1)) idx = 64'(n - 1);
            colour = stop_colour[idx];
         end
         return colour;
      endfunction

      function void note_position(bit [POS_W-1:0] position);
         owed_q.push_back(lookup(position));
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         faults++;
      endtask

      task check_colour(bit [csl_pkg::CHAN_W-1:0] r, bit [csl_pkg::CHAN_W-1:0] g,
                        bit [csl_pkg::CHAN_W-1:0] b, bit [csl_pkg::CHAN_W-1:0] a);
         rgba_type owed;
         rgba_type seen;
         string    names [csl_pkg::NUM_CHANS];
         names = '{"red", "green", "blue", "alpha"};
         seen  = {a, b, g, r};
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected beat %08h", seen));
            return;
         end
         owed = owed_q.pop_front();
         for (int i = 0; i < csl_pkg::NUM_CHANS; i++)
            if (seen[i] !== owed[i])
               report($sformatf("%s expected %0d got %0d", names[i], owed[i], seen[i]));
      endtask

      task flush_leftovers();
         while (owed_q.size() != 0)
            report($sformatf("colour %08h never arrived", owed_q.pop_front()));
      endtask
   endclass

   colour_scoreboard sb = new();
   int unsigned      cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL color_scale_lookup_core");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_strobe === 1'b1)
         sb.check_colour(rsp_red, rsp_green, rsp_blue, rsp_alpha);

   task csr_write(int idx, bit [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= csl_pkg::CSR_ADDR_W'(idx * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task send_position(bit [POS_W-1:0] position);
      @(negedge clock);
      start        <= 1'b1;
      req_position <= position;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_position(position);
   endtask

   task hold_sender(int gap);
      @(negedge clock);
      start <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // upper bits of the narrow registers are junk half the time
   task load_setup(int count, bit mode,
                   bit [csl_pkg::COLOR_W-1:0] colours [csl_pkg::NUM_COLOR_REGS]);
      bit [31:0] v;
      v = $urandom_range(0, 1) ? $urandom : 32'd0;
      v[csl_pkg::COUNT_W-1:0] = csl_pkg::COUNT_W'(count);
      csr_write(csl_pkg::REG_COLOR_COUNT, v);
      v = $urandom_range(0, 1) ? $urandom : 32'd0;
      v[0] = mode;
      csr_write(csl_pkg::REG_GRADIENT_MODE, v);
      for (int i = csl_pkg::REG_COLOR_0; i <= REG_LAST; i++)
         csr_write(i, colours[i - csl_pkg::REG_COLOR_0]);
   endtask

   function bit [csl_pkg::COLOR_W-1:0] pick_colour();
      bit [csl_pkg::COLOR_W-1:0] c;
      case ($urandom_range(0, 5))
         0: c = '0;
         1: c = csl_pkg::WHITE;
         2: for (int i = 0; i < csl_pkg::NUM_CHANS; i++)
               c[csl_pkg::CHAN_W*i +: csl_pkg::CHAN_W] = $urandom_range(0, 1) ? 8'hFF
                                                                              : 8'h00;
         default: c = $urandom;
      endcase
      return c;
   endfunction

   // mostly in range, with a share on bin and segment edges and past 1.0
   function bit [POS_W-1:0] pick_position();
      int m;
      int k;
      int b;
      int edges [4];
      edges = '{0, POS_ONE - 1, POS_ONE, (1 << POS_W) - 1};
      case ($urandom_range(0, 9))
         7: begin
            m = sb.blend_on ? sb.used_stops() - 1 : sb.used_stops();
            if (m < 1) m = 1;
            k = $urandom_range(0, m);
            b = (k * POS_ONE) / m + $urandom_range(0, 2) - 1;
            if (b < 0) b = 0;
            return POS_W'(b);
         end
         8: return POS_W'($urandom_range(POS_ONE, (1 << POS_W) - 1));
         9: return POS_W'(edges[$urandom_range(0, 3)]);
         default: return POS_W'($urandom_range(0, POS_ONE));
      endcase
   endfunction

   initial begin
      bit [csl_pkg::COLOR_W-1:0] colours [csl_pkg::NUM_COLOR_REGS];
      bit [POS_W-1:0]            probe [5];
      int                        dir_count [5];
      bit                        dir_mode [5];
      int                        count;
      bit                        mode;
      int                        left;
      int                        burst;

      reset        = 1'b1;
      start        = 1'b0;
      req_position = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: no stops, so opaque white
      send_position('0);
      send_position('1);
      hold_sender(0);
      wait_drained();

      probe     = '{POS_W'(0), POS_W'(1), POS_W'(POS_ONE / 2), POS_W'(POS_ONE),
                    POS_W'((1 << POS_W) - 1)};
      dir_count = '{1, 2, 6, 7, 0};
      dir_mode  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      for (int d = 0; d < 5; d++) begin
         colours[0] = 32'h00FF00FF;   // rising and falling channels in one segment
         colours[1] = 32'hFF00FF00;
         for (int i = 2; i < csl_pkg::NUM_COLOR_REGS; i++) colours[i] = pick_colour();
         load_setup(dir_count[d], dir_mode[d], colours);
         foreach (probe[j]) send_position(probe[j]);
         hold_sender(0);
         wait_drained();
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin count = 6; mode = 1'b1; end
            1: begin count = 2; mode = 1'b0; end
            2: begin count = 6; mode = 1'b0; end
            3: begin count = 2; mode = 1'b1; end
            default: begin
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(2, 6);
               mode  = 1'($urandom_range(0, 1));
            end
         endcase
         foreach (colours[i]) colours[i] = pick_colour();
         load_setup(count, mode, colours);
         left = PHASE_ITEMS;
         while (left > 0) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
            if (burst > left) burst = left;
            for (int j = 0; j < burst; j++) send_position(pick_position());
            left -= burst;
            hold_sender($urandom_range(0, 6));
            if ($urandom_range(0, 5) == 0)
               while (sb.pending() != 0) @(posedge clock);
         end
         wait_drained();
      end

      wait_drained();
      sb.flush_leftovers();
      if (sb.faults == 0)
         $display("PASS color_scale_lookup_core");
      else
         $display("FAIL color_scale_lookup_core");
      $finish;
   end

endmodule

// File: files.f
hdl/csl_pkg.sv
hdl/csl_csr.sv
hdl/csl_locate.sv
hdl/csl_blend.sv
hdl/color_scale_lookup_core.sv
tb/color_scale_lookup_core_test.sv
